// File: rtl/core/pl0rsm_pkg.sv
// shared types and constants for the pl0 register stack machine
`default_nettype none
package pl0rsm_pkg;

    typedef enum logic [4:0] {
        OP_NOP  = 5'd0,
        OP_LIT  = 5'd1,
        OP_RET  = 5'd2,
        OP_LOD  = 5'd3,
        OP_STO  = 5'd4,
        OP_CAL  = 5'd5,
        OP_INC  = 5'd6,
        OP_JMP  = 5'd7,
        OP_JPC  = 5'd8,
        OP_WRT  = 5'd9,
        OP_RED  = 5'd10,
        OP_HALT = 5'd11,
        OP_NEG  = 5'd12,
        OP_ADD  = 5'd13,
        OP_SUB  = 5'd14,
        OP_MUL  = 5'd15,
        OP_DIV  = 5'd16,
        OP_MOD  = 5'd17,
        OP_EQL  = 5'd18,
        OP_NEQ  = 5'd19,
        OP_LSS  = 5'd20,
        OP_LEQ  = 5'd21,
        OP_GTR  = 5'd22,
        OP_GEQ  = 5'd23
    } opcode_t;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_HALTED   = 2'd1,
        ST_BOUNDS   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_RDREG,
        S_EXEC,
        S_WALK_RD,
        S_WALK_CHK,
        S_ADDR,
        S_MEM_RD,
        S_LOD_WB,
        S_RET_RD1,
        S_RET_RD2,
        S_RET_FIN,
        S_CAL_W1,
        S_CAL_W2,
        S_CAL_W3,
        S_DIV,
        S_DIV_FIN,
        S_MUL_FIN,
        S_DONE,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic rd_regs;
        logic exec;
        logic walk_rd;
        logic walk_chk;
        logic addr_calc;
        logic mem_rd;
        logic lod_wb;
        logic ret_rd1;
        logic ret_rd2;
        logic ret_fin;
        logic cal_w1;
        logic cal_w2;
        logic cal_w3;
        logic div_start;
        logic div_step;
        logic div_fin;
        logic mul_fin;
        logic finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic stopped;
        logic walk_more;
        logic walk_bad;
        logic addr_bad;
        logic div_done;
        logic ret_bad;
        logic cal_ovf;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/pl0rsm_ram.sv
// generic single port ram with registered read
`default_nettype none
module pl0rsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, returns the old data on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/core/pl0rsm_ctrl.sv
// controller state machine sequencing one instruction
`default_nettype none
module pl0rsm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic [4:0]          op,
    output pl0rsm_pkg::dp_cmd_t      cmd,
    input  wire pl0rsm_pkg::dp_stat_t stat
);
    import pl0rsm_pkg::*;

    state_t state_reg, state_next;
    opcode_t op_reg, op_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg    <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode_t'(op);
                    state_next = S_RDREG;
                end
            end
            S_RDREG:
            begin
                state_next = stat.stopped ? S_DONE : S_EXEC;
            end
            S_EXEC:
            begin
                priority case (op_reg)
                    OP_RET:  state_next = stat.ret_bad ? S_DONE : S_RET_RD1;
                    OP_LOD, OP_STO: state_next = S_WALK_RD;
                    OP_CAL:  state_next = stat.cal_ovf ? S_DONE : S_WALK_RD;
                    OP_MUL:  state_next = S_MUL_FIN;
                    OP_DIV, OP_MOD: state_next = S_DIV;
                    default: state_next = S_DONE;
                endcase
            end
            S_WALK_RD:
            begin
                state_next = stat.walk_more ? S_WALK_CHK : S_ADDR;
            end
            S_WALK_CHK:
            begin
                state_next = stat.walk_bad ? S_DONE : S_WALK_RD;
            end
            S_ADDR:
            begin
                if (op_reg == OP_CAL)
                begin
                    state_next = S_CAL_W1;
                end
                else
                begin
                    state_next = stat.addr_bad ? S_DONE : S_MEM_RD;
                end
            end
            S_MEM_RD:
            begin
                state_next = (op_reg == OP_LOD) ? S_LOD_WB : S_DONE;
            end
            S_LOD_WB:  state_next = S_DONE;
            S_RET_RD1: state_next = S_RET_RD2;
            S_RET_RD2: state_next = S_RET_FIN;
            S_RET_FIN: state_next = S_DONE;
            S_CAL_W1:  state_next = S_CAL_W2;
            S_CAL_W2:  state_next = S_CAL_W3;
            S_CAL_W3:  state_next = S_DONE;
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIV_FIN;
                end
            end
            S_DIV_FIN: state_next = S_DONE;
            S_MUL_FIN: state_next = S_DONE;
            S_DONE:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR:   cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_RDREG:   cmd.rd_regs = 1'b1;
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = (op_reg == OP_DIV) || (op_reg == OP_MOD);
            end
            S_WALK_RD:  cmd.walk_rd = 1'b1;
            S_WALK_CHK: cmd.walk_chk = 1'b1;
            S_ADDR:     cmd.addr_calc = 1'b1;
            S_MEM_RD:   cmd.mem_rd = 1'b1;
            S_LOD_WB:   cmd.lod_wb = 1'b1;
            S_RET_RD1:  cmd.ret_rd1 = 1'b1;
            S_RET_RD2:  cmd.ret_rd2 = 1'b1;
            S_RET_FIN:  cmd.ret_fin = 1'b1;
            S_CAL_W1:   cmd.cal_w1 = 1'b1;
            S_CAL_W2:   cmd.cal_w2 = 1'b1;
            S_CAL_W3:   cmd.cal_w3 = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_DIV_FIN:  cmd.div_fin = 1'b1;
            S_MUL_FIN:  cmd.mul_fin = 1'b1;
            S_DONE:     cmd.finish = 1'b1;
            S_OUT:      out_valid = 1'b1;
            default:    cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/pl0rsm_dp.sv
// datapath: register file, stack memory, pointers, divider
`default_nettype none
module pl0rsm_dp #(
    parameter int STACK_DEPTH = 128,
    parameter int NUM_REGS    = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pl0rsm_pkg::dp_cmd_t  cmd,
    output pl0rsm_pkg::dp_stat_t      stat,
    input  wire logic [4:0]           req_type,
    input  wire logic [3:0]           reg_sel,
    input  wire logic [3:0]           level,
    input  wire logic signed [31:0]   m_field,
    input  wire logic signed [31:0]   read_value,
    output logic [15:0]               next_pc,
    output logic [7:0]                stack_ptr,
    output logic [6:0]                base_ptr,
    output logic                      write_valid,
    output logic signed [31:0]        write_value,
    output logic [1:0]                status
);
    import pl0rsm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = AW + 1;
    localparam int RW = $clog2(NUM_REGS);
    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW + 1);

    // latched instruction
    logic [4:0]    op_reg;
    logic [RW-1:0] r_reg, lreg_reg, mreg_reg;
    logic [3:0]    lraw_reg;
    logic [31:0]   m_reg, rd_reg;

    // architectural state
    logic [15:0]   pc_reg;
    logic [SW-1:0] sp_reg;
    logic [AW-1:0] bp_reg;
    logic          stopped_reg;
    logic [NUM_REGS-1:0] rvalid_reg;
    logic [DW-1:0] rf [NUM_REGS];

    // operand and work registers
    logic [DW-1:0] a_reg, b_reg, rr_reg, prod_reg;
    logic [AW-1:0] walk_reg, addr_reg;
    logic [3:0]    lcnt_reg;
    logic [15:0]   npc_reg;
    logic [1:0]    st_reg;
    logic          wv_reg;
    logic [31:0]   wval_reg;
    logic [AW:0]   clr_reg;

    // divider
    logic [DW-1:0] q_reg, rem_reg, dvs_reg;
    logic [CW-1:0] dcnt_reg;
    logic          na_reg, nb_reg;

    // result registers
    logic [15:0]   o_pc_reg;
    logic [7:0]    o_sp_reg;
    logic [6:0]    o_bp_reg;
    logic          o_wv_reg;
    logic [31:0]   o_wval_reg;
    logic [1:0]    o_st_reg;

    // stack ram port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    pl0rsm_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [DW-1:0] sext32(input logic [31:0] v);
        logic [63:0] t;
        t = {{32{v[31]}}, v};
        return t[DW-1:0];
    endfunction

    function automatic logic link_ok(input logic [DW-1:0] v);
        return !v[DW-1] && (v < DW'(STACK_DEPTH));
    endfunction

    // register file read with reset-as-zero
    logic [DW-1:0] rf_r, rf_l, rf_m;
    assign rf_r = rvalid_reg[r_reg] ? rf[r_reg] : '0;
    assign rf_l = rvalid_reg[lreg_reg] ? rf[lreg_reg] : '0;
    assign rf_m = rvalid_reg[mreg_reg] ? rf[mreg_reg] : '0;

    // ops whose execute step writes the register file
    logic rf_exec_wr;
    assign rf_exec_wr = !(op_reg inside {OP_RET, OP_CAL, OP_INC, OP_JMP, OP_JPC,
                                         OP_WRT, OP_HALT});

    // signed compare helpers
    logic lt_ab, lt_ba;
    assign lt_ab = $signed(a_reg) < $signed(b_reg);
    assign lt_ba = $signed(b_reg) < $signed(a_reg);

    // stack address from base and offset register
    logic [DW-1:0] bneg;
    logic          addr_bad;
    logic [AW-1:0] addr_calc;
    always_comb
    begin
        bneg      = '0 - b_reg;
        addr_bad  = 1'b0;
        addr_calc = walk_reg;
        if (b_reg[DW-1])
        begin
            if (bneg >= DW'(STACK_DEPTH) ||
                ({{(DW-AW){1'b0}}, walk_reg} + bneg) >= DW'(STACK_DEPTH))
            begin
                addr_bad = 1'b1;
            end
            addr_calc = walk_reg + bneg[AW-1:0];
        end
        else
        begin
            if (b_reg > {{(DW-AW){1'b0}}, walk_reg})
            begin
                addr_bad = 1'b1;
            end
            addr_calc = walk_reg - b_reg[AW-1:0];
        end
    end

    // inc bounds
    logic signed [33:0] inc_nsp;
    assign inc_nsp = $signed({{(34-SW){1'b0}}, sp_reg}) - $signed({{2{m_reg[31]}}, m_reg});

    // divider step
    logic [DW:0]   dtrial;
    logic [DW-1:0] dshift;
    assign dshift = {rem_reg[DW-2:0], q_reg[DW-1]};
    assign dtrial = {1'b0, dshift} - {1'b0, dvs_reg};

    // ram port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = walk_reg;
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg[AW-1:0];
        end
        else if (cmd.exec && op_reg == OP_RET)
        begin
            ram_addr = bp_reg - AW'(1);
        end
        else if (cmd.ret_rd1)
        begin
            ram_addr = bp_reg - AW'(2);
        end
        else if (cmd.mem_rd)
        begin
            ram_addr  = addr_reg;
            ram_we    = (op_reg == OP_STO);
            ram_wdata = rf_r;
        end
        else if (cmd.cal_w1)
        begin
            ram_we    = 1'b1;
            ram_addr  = AW'(sp_reg - SW'(1));
            ram_wdata = DW'(walk_reg);
        end
        else if (cmd.cal_w2)
        begin
            ram_we    = 1'b1;
            ram_addr  = AW'(sp_reg - SW'(2));
            ram_wdata = DW'(bp_reg);
        end
        else if (cmd.cal_w3)
        begin
            ram_we    = 1'b1;
            ram_addr  = AW'(sp_reg - SW'(3));
            ram_wdata = DW'(pc_reg + 16'd1);
        end
    end

    // status to controller
    always_comb
    begin
        stat.clr_done  = (clr_reg == (AW+1)'(STACK_DEPTH - 1));
        stat.stopped   = stopped_reg;
        stat.walk_more = (lcnt_reg != 4'd0);
        stat.walk_bad  = !link_ok(ram_rdata);
        stat.addr_bad  = addr_bad;
        stat.div_done  = (dcnt_reg == CW'(DW - 1));
        stat.ret_bad   = (bp_reg < AW'(2));
        stat.cal_ovf   = (sp_reg < SW'(3));
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            sp_reg      <= SW'(STACK_DEPTH);
            bp_reg      <= AW'(STACK_DEPTH - 1);
            stopped_reg <= 1'b0;
            rvalid_reg  <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step && !stat.clr_done)
            begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
            if (cmd.finish && !stopped_reg)
            begin
                pc_reg <= npc_reg;
                if (st_reg != ST_RUNNING)
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.exec && op_reg == OP_INC && inc_nsp >= 0 &&
                inc_nsp <= 34'(STACK_DEPTH))
            begin
                sp_reg <= inc_nsp[SW-1:0];
            end
            if (cmd.ret_fin && st_reg == ST_RUNNING)
            begin
                sp_reg <= SW'(bp_reg) + SW'(1);
                bp_reg <= walk_reg;
            end
            if (cmd.cal_w3)
            begin
                bp_reg <= AW'(sp_reg - SW'(1));
            end
            if ((cmd.exec && rf_exec_wr) || cmd.lod_wb || cmd.div_fin || cmd.mul_fin)
            begin
                rvalid_reg[r_reg] <= 1'b1;
            end
        end
    end

    // register file and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req_type;
            r_reg    <= RW'(reg_sel);
            lraw_reg <= level;
            lreg_reg <= RW'(level);
            mreg_reg <= RW'(m_field);
            m_reg    <= m_field;
            rd_reg   <= read_value;
        end
        if (cmd.rd_regs)
        begin
            a_reg    <= rf_l;
            b_reg    <= rf_m;
            rr_reg   <= rf_r;
            npc_reg  <= pc_reg + 16'd1;
            st_reg   <= ST_RUNNING;
            wv_reg   <= 1'b0;
            wval_reg <= '0;
            walk_reg <= bp_reg;
            lcnt_reg <= lraw_reg;
        end
        if (cmd.exec)
        begin
            prod_reg <= a_reg * b_reg;
            unique case (op_reg)
                OP_LIT:  rf[r_reg] <= sext32(m_reg);
                OP_RET:
                begin
                    if (stat.ret_bad)
                    begin
                        st_reg <= ST_BOUNDS;
                    end
                end
                OP_CAL:
                begin
                    if (stat.cal_ovf)
                    begin
                        st_reg <= ST_OVERFLOW;
                    end
                end
                OP_INC:
                begin
                    if (inc_nsp < 0)
                    begin
                        st_reg <= ST_OVERFLOW;
                    end
                    else if (inc_nsp > 34'(STACK_DEPTH))
                    begin
                        st_reg <= ST_BOUNDS;
                    end
                end
                OP_JMP:  npc_reg <= m_reg[15:0];
                OP_JPC:
                begin
                    if (rr_reg == '0)
                    begin
                        npc_reg <= m_reg[15:0];
                    end
                end
                OP_WRT:
                begin
                    wv_reg   <= 1'b1;
                    wval_reg <= 32'({{32{1'b0}}, rr_reg});
                end
                OP_RED:  rf[r_reg] <= sext32(rd_reg);
                OP_HALT: st_reg <= ST_HALTED;
                OP_NEG:  rf[r_reg] <= '0 - rr_reg;
                OP_ADD:  rf[r_reg] <= a_reg + b_reg;
                OP_SUB:  rf[r_reg] <= a_reg - b_reg;
                OP_EQL:  rf[r_reg] <= DW'(a_reg == b_reg);
                OP_NEQ:  rf[r_reg] <= DW'(a_reg != b_reg);
                OP_LSS:  rf[r_reg] <= DW'(lt_ab);
                OP_LEQ:  rf[r_reg] <= DW'(!lt_ba);
                OP_GTR:  rf[r_reg] <= DW'(lt_ba);
                OP_GEQ:  rf[r_reg] <= DW'(!lt_ab);
                default: rf[r_reg] <= rf_r;
            endcase
        end
        // static link walk
        if (cmd.walk_rd && stat.walk_more)
        begin
            lcnt_reg <= lcnt_reg - 4'd1;
        end
        if (cmd.walk_chk)
        begin
            if (stat.walk_bad)
            begin
                st_reg <= ST_BOUNDS;
            end
            else
            begin
                walk_reg <= ram_rdata[AW-1:0];
            end
        end
        if (cmd.addr_calc)
        begin
            addr_reg <= addr_calc;
            if (op_reg != OP_CAL && addr_bad)
            begin
                st_reg <= ST_BOUNDS;
            end
        end
        if (cmd.lod_wb)
        begin
            rf[r_reg] <= ram_rdata;
        end
        // return frame, left alone when the saved base is bad
        if (cmd.ret_rd1)
        begin
            if (!link_ok(ram_rdata))
            begin
                st_reg <= ST_BOUNDS;
            end
            a_reg <= ram_rdata;
        end
        if (cmd.ret_rd2 && st_reg == ST_RUNNING)
        begin
            npc_reg  <= ram_rdata[15:0];
            walk_reg <= a_reg[AW-1:0];
        end
        if (cmd.cal_w3)
        begin
            npc_reg <= m_reg[15:0];
        end
        if (cmd.mul_fin)
        begin
            rf[r_reg] <= prod_reg;
        end
        // restoring divider, one quotient bit per cycle
        if (cmd.div_start)
        begin
            na_reg   <= a_reg[DW-1];
            nb_reg   <= b_reg[DW-1];
            q_reg    <= a_reg[DW-1] ? '0 - a_reg : a_reg;
            dvs_reg  <= b_reg[DW-1] ? '0 - b_reg : b_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + CW'(1);
            if (!dtrial[DW])
            begin
                rem_reg <= dtrial[DW-1:0];
                q_reg   <= {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= dshift;
                q_reg   <= {q_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.div_fin)
        begin
            if (dvs_reg == '0)
            begin
                rf[r_reg] <= '0;
            end
            else if (op_reg == OP_MOD)
            begin
                rf[r_reg] <= na_reg ? '0 - rem_reg : rem_reg;
            end
            else
            begin
                rf[r_reg] <= (na_reg != nb_reg) ? '0 - q_reg : q_reg;
            end
        end
        // result capture
        if (cmd.finish)
        begin
            if (stopped_reg)
            begin
                o_pc_reg   <= pc_reg;
                o_sp_reg   <= 8'(sp_reg);
                o_bp_reg   <= 7'(bp_reg);
                o_wv_reg   <= 1'b0;
                o_wval_reg <= '0;
                o_st_reg   <= ST_HALTED;
            end
            else
            begin
                o_pc_reg   <= npc_reg;
                o_sp_reg   <= 8'(sp_reg);
                o_bp_reg   <= 7'(bp_reg);
                o_wv_reg   <= wv_reg;
                o_wval_reg <= wval_reg;
                o_st_reg   <= st_reg;
            end
        end
    end

    assign next_pc     = o_pc_reg;
    assign stack_ptr   = o_sp_reg;
    assign base_ptr    = o_bp_reg;
    assign write_valid = o_wv_reg;
    assign write_value = o_wval_reg;
    assign status      = o_st_reg;
endmodule
`default_nettype wire

// File: rtl/core/pl0_register_stack_machine_top.sv
// top level of the pl0 register stack machine
//
// channel | signals                                          | direction
// in      | in_valid/in_ready, req_type reg_sel level m_field read_value | to block
// out     | out_valid/out_ready, next_pc stack_ptr base_ptr write_valid write_value status | from block
//
// one instruction at a time: lod/sto/cal walk the static links with a read
// and a check step per link on the single stack ram port, div/mod compute
// one quotient bit per cycle.
// after reset a clearing pass zeroes every stack word before the first
// transaction is taken. a held result stalls the next transaction.
`default_nettype none
module pl0_register_stack_machine_top #(
    parameter int STACK_DEPTH = 128,
    parameter int NUM_REGS    = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [4:0]         req_type,
    input  wire logic [3:0]         reg_sel,
    input  wire logic [3:0]         level,
    input  wire logic signed [31:0] m_field,
    input  wire logic signed [31:0] read_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             next_pc,
    output logic [7:0]              stack_ptr,
    output logic [6:0]              base_ptr,
    output logic                    write_valid,
    output logic signed [31:0]      write_value,
    output logic [1:0]              status
);
    import pl0rsm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pl0rsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (req_type),
        .cmd       (cmd),
        .stat      (stat)
    );

    pl0rsm_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_REGS    (NUM_REGS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .reg_sel     (reg_sel),
        .level       (level),
        .m_field     (m_field),
        .read_value  (read_value),
        .next_pc     (next_pc),
        .stack_ptr   (stack_ptr),
        .base_ptr    (base_ptr),
        .write_valid (write_valid),
        .write_value (write_value),
        .status      (status)
    );
endmodule
`default_nettype wire
